// ===== src/agf_pkg.sv =====
// ----------------------------------------------------------------------------
// agf_pkg
// Shared codes and state types for the aggregating FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package agf_pkg;

  // request actions
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // result status codes
  localparam logic [1:0] STS_DONE       = 2'd0;
  localparam logic [1:0] STS_POP_EMPTY  = 2'd1;
  localparam logic [1:0] STS_PUSH_FULL  = 2'd2;

  // configuration register indexes
  localparam logic CFG_GCD_EN = 1'b0;
  localparam logic CFG_LCM_EN = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_PCOMB, S_XRD, S_XRDW, S_XCOMB, S_POP, S_FRDW, S_REPORT, S_RCOMB, S_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    C_IDLE, C_GCD, C_GCDW, C_QDIV, C_MDIV, C_MUL, C_DONE
  } comb_state_t;

endpackage

`default_nettype wire

// ===== src/agf_if.sv =====
// ----------------------------------------------------------------------------
// agf_in_if / agf_out_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface agf_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] value;
  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface agf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] min_value;
  logic [31:0] max_value;
  logic [31:0] or_value;
  logic [31:0] and_value;
  logic [31:0] gcd_value;
  logic [31:0] lcm_value;
  logic        lcm_saturated;
  logic [10:0] entry_count;
  logic        is_empty;
  logic [1:0]  status;
  modport source (output valid, output min_value, output max_value, output or_value,
                  output and_value, output gcd_value, output lcm_value,
                  output lcm_saturated, output entry_count, output is_empty,
                  output status, input ready);
  modport sink   (input valid, input min_value, input max_value, input or_value,
                  input and_value, input gcd_value, input lcm_value,
                  input lcm_saturated, input entry_count, input is_empty,
                  input status, output ready);
endinterface

`default_nettype wire

// ===== src/aggregate_fifo_min_max_gcd.sv =====
// ----------------------------------------------------------------------------
// aggregate_fifo_min_max_gcd
// Two-stack FIFO of words reporting min, max, OR, AND, GCD and LCM.
// ----------------------------------------------------------------------------
// Each request pushes a word or pops the oldest one, and gives one result with
// the aggregates of what is then held. Requests are taken one at a time while
// in_ch.ready is high. Every merge of two aggregates runs in one shared
// combine unit whose divider yields one bit a cycle: a merge runs one divide
// per Euclid step of the two GCDs (a few when values are small, a few dozen
// at worst), and for the LCM up to two more and a shift-add multiply. A push
// onto a non-empty back stack takes one merge; a pop that finds the front
// stack empty first moves the back stack over, one merge per word moved after
// the first, and every result with entries on both stacks adds one more
// merge. Averaged over a queue's life this is a couple of merges per request.
// Stores are undefined after reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module aggregate_fifo_min_max_gcd #(
  parameter int CAPACITY   = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  agf_in_if.sink     in_ch,
  agf_out_if.source  out_ch,
  input  wire logic  cfg_we,
  input  wire logic  cfg_index,
  input  wire logic  cfg_data
);

  localparam int DW = DATA_WIDTH;
  localparam int AW = 6 * DW + 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AD = $clog2(CAPACITY);

  typedef struct packed {
    logic [DW-1:0] mn, mx, orv, andv, g, l;
    logic          ls;
  } agg_t;

  function automatic agg_t leaf(input logic [DW-1:0] v);
    agg_t r;
    r.mn = v; r.mx = v; r.orv = v; r.andv = v; r.g = v; r.l = v;
    r.ls = 1'b0;
    return r;
  endfunction

  // config registers
  logic gcd_en_r, lcm_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gcd_en_r <= 1'b0;
      lcm_en_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        agf_pkg::CFG_GCD_EN: gcd_en_r <= cfg_data;
        agf_pkg::CFG_LCM_EN: lcm_en_r <= cfg_data;
      endcase
    end
  end

  // back stack holds raw words (read when moved); front stack holds
  // running aggregates (read on pop to expose the new top)
  logic [DW-1:0] bval_mem [CAPACITY];
  agg_t          fagg_mem [CAPACITY];
  logic [DW-1:0] bval_q, bwdata;
  agg_t          fagg_q, fwdata;
  logic [AD-1:0] braddr, bwaddr, fraddr, fwaddr;
  logic          bwe, fwe;

  always_ff @(posedge clk) begin
    if (bwe) bval_mem[bwaddr] <= bwdata;
    if (fwe) fagg_mem[fwaddr] <= fwdata;
    bval_q <= bval_mem[braddr];
    fagg_q <= fagg_mem[fraddr];
  end

  agf_pkg::top_state_t st_r, st_nxt;
  logic [CW-1:0] bd_r, bd_nxt, fd_r, fd_nxt, total;
  logic [DW-1:0] val_r, val_nxt, in_v;
  agg_t          btop_r, btop_nxt, ftop_r, ftop_nxt, res_r, res_nxt;
  logic          have_r, have_nxt;
  logic [1:0]    sts_r, sts_nxt;

  // shared combine unit
  agg_t cx, cy, c_r;
  logic c_start, c_done;
  logic [AW-1:0] c_rv;

  agf_combine #(.W(DW)) u_combine (
    .clk(clk), .rst_n(rst_n), .start(c_start), .x_i(cx), .y_i(cy),
    .done(c_done), .r_o(c_rv)
  );
  assign c_r = agg_t'(c_rv);

  // result register
  logic        ov_r, ov_nxt, out_load;
  logic [31:0] omin_r, omax_r, oor_r, oand_r, ogcd_r, olcm_r;
  logic        osat_r, oemp_r;
  logic [10:0] ocnt_r;
  logic [1:0]  osts_r;

  assign total = bd_r + fd_r;
  assign in_v  = DW'(in_ch.value);
  assign in_ch.ready = (st_r == agf_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= agf_pkg::S_IDLE;
    else        st_r <= st_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    bd_nxt = bd_r; fd_nxt = fd_r; val_nxt = val_r;
    btop_nxt = btop_r; ftop_nxt = ftop_r; res_nxt = res_r;
    have_nxt = have_r; sts_nxt = sts_r;
    c_start = 1'b0; cx = ftop_r; cy = btop_r;
    bwe = 1'b0; bwaddr = bd_r[AD-1:0]; bwdata = val_r;
    fwe = 1'b0; fwaddr = fd_r[AD-1:0]; fwdata = c_r;
    braddr = AD'(bd_r - CW'(1));
    fraddr = AD'(fd_r - CW'(2));
    out_load = 1'b0;
    unique case (st_r)
      agf_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          sts_nxt = agf_pkg::STS_DONE;
          if (in_ch.action == agf_pkg::ACT_PUSH) begin
            if (total >= CW'(CAPACITY)) begin
              sts_nxt = agf_pkg::STS_PUSH_FULL;
              st_nxt = agf_pkg::S_REPORT;
            end else if (bd_r == '0) begin
              bwe = 1'b1; bwdata = in_v;
              btop_nxt = leaf(in_v);
              bd_nxt = CW'(1);
              st_nxt = agf_pkg::S_REPORT;
            end else begin
              c_start = 1'b1; cx = btop_r; cy = leaf(in_v);
              val_nxt = in_v;
              st_nxt = agf_pkg::S_PCOMB;
            end
          end else begin
            if (total == '0) begin
              sts_nxt = agf_pkg::STS_POP_EMPTY;
              st_nxt = agf_pkg::S_REPORT;
            end else if (fd_r == '0) begin
              st_nxt = agf_pkg::S_XRD;
            end else begin
              st_nxt = agf_pkg::S_POP;
            end
          end
        end
      end
      agf_pkg::S_PCOMB: begin
        if (c_done) begin
          bwe = 1'b1;
          btop_nxt = c_r;
          bd_nxt = bd_r + CW'(1);
          st_nxt = agf_pkg::S_REPORT;
        end
      end
      // move: newest back word goes onto the front stack
      agf_pkg::S_XRD: begin
        bd_nxt = bd_r - CW'(1);
        st_nxt = agf_pkg::S_XRDW;
      end
      agf_pkg::S_XRDW: begin
        if (fd_r == '0) begin
          fwe = 1'b1; fwdata = leaf(bval_q);
          ftop_nxt = leaf(bval_q);
          fd_nxt = CW'(1);
          st_nxt = (bd_r == '0) ? agf_pkg::S_POP : agf_pkg::S_XRD;
        end else begin
          c_start = 1'b1; cx = ftop_r; cy = leaf(bval_q);
          st_nxt = agf_pkg::S_XCOMB;
        end
      end
      agf_pkg::S_XCOMB: begin
        if (c_done) begin
          fwe = 1'b1;
          ftop_nxt = c_r;
          fd_nxt = fd_r + CW'(1);
          st_nxt = (bd_r == '0) ? agf_pkg::S_POP : agf_pkg::S_XRD;
        end
      end
      agf_pkg::S_POP: begin
        fd_nxt = fd_r - CW'(1);
        st_nxt = (fd_r >= CW'(2)) ? agf_pkg::S_FRDW : agf_pkg::S_REPORT;
      end
      agf_pkg::S_FRDW: begin
        ftop_nxt = fagg_q;
        st_nxt = agf_pkg::S_REPORT;
      end
      agf_pkg::S_REPORT: begin
        have_nxt = 1'b1;
        if (fd_r != '0 && bd_r != '0) begin
          c_start = 1'b1;
          st_nxt = agf_pkg::S_RCOMB;
        end else begin
          if (fd_r != '0)      res_nxt = ftop_r;
          else if (bd_r != '0) res_nxt = btop_r;
          else begin
            res_nxt = '0;
            have_nxt = 1'b0;
          end
          st_nxt = agf_pkg::S_OUT;
        end
      end
      agf_pkg::S_RCOMB: begin
        if (c_done) begin
          res_nxt = c_r;
          st_nxt = agf_pkg::S_OUT;
        end
      end
      agf_pkg::S_OUT: begin
        if (!ov_r || out_ch.ready) begin
          out_load = 1'b1;
          st_nxt = agf_pkg::S_IDLE;
        end
      end
      default: st_nxt = agf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (out_load)                  ov_nxt = 1'b1;
    else if (ov_r && out_ch.ready) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bd_r <= '0;
      fd_r <= '0;
      ov_r <= 1'b0;
    end else begin
      bd_r <= bd_nxt;
      fd_r <= fd_nxt;
      ov_r <= ov_nxt;
    end
    val_r <= val_nxt; btop_r <= btop_nxt; ftop_r <= ftop_nxt;
    res_r <= res_nxt; have_r <= have_nxt; sts_r <= sts_nxt;
    if (out_load) begin
      omin_r <= 32'(res_r.mn);
      omax_r <= 32'(res_r.mx);
      oor_r  <= 32'(res_r.orv);
      oand_r <= 32'(res_r.andv);
      ogcd_r <= (have_r && gcd_en_r) ? 32'(res_r.g) : 32'd0;
      olcm_r <= (have_r && lcm_en_r) ? 32'(res_r.l) : 32'd0;
      osat_r <= have_r && lcm_en_r && res_r.ls;
      ocnt_r <= 11'(total);
      oemp_r <= (total == '0);
      osts_r <= sts_r;
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.min_value     = omin_r;
  assign out_ch.max_value     = omax_r;
  assign out_ch.or_value      = oor_r;
  assign out_ch.and_value     = oand_r;
  assign out_ch.gcd_value     = ogcd_r;
  assign out_ch.lcm_value     = olcm_r;
  assign out_ch.lcm_saturated = osat_r;
  assign out_ch.entry_count   = ocnt_r;
  assign out_ch.is_empty      = oemp_r;
  assign out_ch.status        = osts_r;

endmodule

`default_nettype wire

// ===== src/agf_divider.sv =====
// ----------------------------------------------------------------------------
// agf_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module agf_divider #(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quotient,
  output logic [W-1:0]      remainder
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     quo_r, quo_nxt, rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [W:0]       trial;

  always_comb begin
    trial    = {rem_r, quo_r[W-1]};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = CNT_W'(W);
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ===== src/agf_combine.sv =====
// ----------------------------------------------------------------------------
// agf_combine
// Merges two aggregates; GCD by Euclid and LCM through the shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

module agf_combine #(
  parameter int W = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [6*W:0]     x_i,
  input  wire logic [6*W:0]     y_i,
  output logic                  done,
  output logic [6*W:0]          r_o
);

  typedef struct packed {
    logic [W-1:0] mn, mx, orv, andv, g, l;
    logic         ls;
  } agg_t;

  localparam logic [W-1:0] MAXW = '1;

  agf_pkg::comb_state_t st_r, st_nxt;
  agg_t         x_r, x_nxt, y_r, y_nxt, res_r, res_nxt, xi, yi;
  logic [W-1:0] a_r, a_nxt, b_r, b_nxt, q_r, q_nxt;
  logic [W-1:0] acc_r, acc_nxt, mc_r, mc_nxt, mp_r, mp_nxt;
  logic         ph_r, ph_nxt;
  logic         div_start, div_done;
  logic [W-1:0] div_dvd, div_dvs, div_quo, div_rem;

  agf_divider #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(div_dvs), .done(div_done), .quotient(div_quo), .remainder(div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= agf_pkg::C_IDLE;
    else        st_r <= st_nxt;
  end

  always_comb begin
    xi = agg_t'(x_i);
    yi = agg_t'(y_i);
    st_nxt = st_r;
    x_nxt = x_r; y_nxt = y_r; res_nxt = res_r;
    a_nxt = a_r; b_nxt = b_r; q_nxt = q_r; ph_nxt = ph_r;
    acc_nxt = acc_r; mc_nxt = mc_r; mp_nxt = mp_r;
    div_start = 1'b0;
    div_dvd = a_r;
    div_dvs = b_r;
    unique case (st_r)
      agf_pkg::C_IDLE: begin
        if (start) begin
          x_nxt = xi;
          y_nxt = yi;
          res_nxt = '0;
          res_nxt.mn   = (xi.mn < yi.mn) ? xi.mn : yi.mn;
          res_nxt.mx   = (xi.mx > yi.mx) ? xi.mx : yi.mx;
          res_nxt.orv  = xi.orv | yi.orv;
          res_nxt.andv = xi.andv & yi.andv;
          a_nxt = xi.g;
          b_nxt = yi.g;
          ph_nxt = 1'b0;
          st_nxt = agf_pkg::C_GCD;
        end
      end
      agf_pkg::C_GCD: begin
        if (b_r == '0) begin
          if (!ph_r) begin
            res_nxt.g = a_r;
            if ((!x_r.ls && x_r.l == '0) || (!y_r.ls && y_r.l == '0)) begin
              res_nxt.l  = '0;
              res_nxt.ls = 1'b0;
              st_nxt = agf_pkg::C_DONE;
            end else if (x_r.ls || y_r.ls) begin
              res_nxt.l  = MAXW;
              res_nxt.ls = 1'b1;
              st_nxt = agf_pkg::C_DONE;
            end else begin
              a_nxt = x_r.l;
              b_nxt = y_r.l;
              ph_nxt = 1'b1;
            end
          end else begin
            // q = x.l / gcd(x.l, y.l)
            div_start = 1'b1;
            div_dvd = x_r.l;
            div_dvs = a_r;
            st_nxt = agf_pkg::C_QDIV;
          end
        end else begin
          div_start = 1'b1;
          st_nxt = agf_pkg::C_GCDW;
        end
      end
      agf_pkg::C_GCDW: begin
        if (div_done) begin
          a_nxt = b_r;
          b_nxt = div_rem;
          st_nxt = agf_pkg::C_GCD;
        end
      end
      agf_pkg::C_QDIV: begin
        if (div_done) begin
          q_nxt = div_quo;
          div_start = 1'b1;
          div_dvd = MAXW;
          div_dvs = y_r.l;
          st_nxt = agf_pkg::C_MDIV;
        end
      end
      agf_pkg::C_MDIV: begin
        if (div_done) begin
          if (q_r > div_quo) begin
            res_nxt.l  = MAXW;
            res_nxt.ls = 1'b1;
            st_nxt = agf_pkg::C_DONE;
          end else begin
            acc_nxt = '0;
            mc_nxt = y_r.l;
            mp_nxt = q_r;
            st_nxt = agf_pkg::C_MUL;
          end
        end
      end
      agf_pkg::C_MUL: begin
        // shift-add; product is known to fit the word
        if (mp_r == '0) begin
          res_nxt.l  = acc_r;
          res_nxt.ls = 1'b0;
          st_nxt = agf_pkg::C_DONE;
        end else begin
          if (mp_r[0]) acc_nxt = acc_r + mc_r;
          mc_nxt = {mc_r[W-2:0], 1'b0};
          mp_nxt = {1'b0, mp_r[W-1:1]};
        end
      end
      agf_pkg::C_DONE: st_nxt = agf_pkg::C_IDLE;
      default: st_nxt = agf_pkg::C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; y_r <= y_nxt; res_r <= res_nxt;
    a_r <= a_nxt; b_r <= b_nxt; q_r <= q_nxt; ph_r <= ph_nxt;
    acc_r <= acc_nxt; mc_r <= mc_nxt; mp_r <= mp_nxt;
  end

  assign done = (st_r == agf_pkg::C_DONE);
  assign r_o  = res_r;

endmodule

`default_nettype wire

// ===== src/agf_checker.sv =====
// ----------------------------------------------------------------------------
// agf_checker
// Port-level checks on results of the aggregating FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

module agf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] min_value,
  input wire logic [31:0] max_value,
  input wire logic [31:0] or_value,
  input wire logic [31:0] and_value,
  input wire logic [31:0] gcd_value,
  input wire logic [31:0] lcm_value,
  input wire logic [10:0] entry_count,
  input wire logic        is_empty,
  input wire logic [1:0]  status
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(min_value) && $stable(entry_count)
      && $stable(status))
    else $error("stalled result changed");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_empty |-> min_value == 32'd0 && max_value == 32'd0 &&
      or_value == 32'd0 && and_value == 32'd0 && gcd_value == 32'd0 && lcm_value == 32'd0)
    else $error("empty queue reported nonzero aggregate");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (is_empty == (entry_count == 11'd0)) &&
      (status != agf_pkg::STS_POP_EMPTY || is_empty))
    else $error("empty flag, count and status disagree");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_empty |-> min_value <= max_value && (and_value & ~or_value) == 32'd0)
    else $error("aggregates inconsistent");

endmodule

bind aggregate_fifo_min_max_gcd agf_checker u_agf_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .min_value(out_ch.min_value), .max_value(out_ch.max_value),
  .or_value(out_ch.or_value), .and_value(out_ch.and_value),
  .gcd_value(out_ch.gcd_value), .lcm_value(out_ch.lcm_value),
  .entry_count(out_ch.entry_count), .is_empty(out_ch.is_empty),
  .status(out_ch.status)
);

`default_nettype wire

// ===== bench/tb_aggregate_fifo_min_max_gcd.sv =====
// ----------------------------------------------------------------------------
// tb_aggregate_fifo_min_max_gcd
// Self-checking bench for the aggregating two-stack FIFO.
// ----------------------------------------------------------------------------
// A queue of pending requests feeds a clocked driver; a clocked monitor takes
// results with random stalls and checks every field against a shadow FIFO
// whose aggregates are folded from its contents at each accepted request.
// The run goes through all enable settings, a deep fill with a long receiver
// hold-off, refused pops, and random push/pop traffic.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_aggregate_fifo_min_max_gcd;

  localparam int DEPTH_MAX   = 1024;
  localparam int FILL_DEPTH  = 150;
  localparam int CYCLE_LIMIT = 40_000_000;

  typedef struct packed {
    logic        action;
    logic [31:0] value;
  } fifo_req_t;

  typedef struct packed {
    logic [31:0] min_value;
    logic [31:0] max_value;
    logic [31:0] or_value;
    logic [31:0] and_value;
    logic [31:0] gcd_value;
    logic [31:0] lcm_value;
    logic        lcm_saturated;
    logic [10:0] entry_count;
    logic        is_empty;
    logic [1:0]  status;
  } fifo_report_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic cfg_data;

  agf_in_if  in_ch ();
  agf_out_if out_ch ();

  aggregate_fifo_min_max_gcd u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // shadow state: contents oldest first, plus the enable registers
  logic [31:0]  shadow_q[$];
  logic         shadow_gcd_en;
  logic         shadow_lcm_en;
  fifo_req_t    pending_q[$];
  fifo_report_t report_q[$];

  int  errors;
  int  cycles;
  int  n_reports;
  int  n_refused;
  int  n_saturated;
  bit  calm;        // no idling on either side
  int  hold_req;    // long receiver hold-off, picked up by the hold counter

  function automatic logic [31:0] euclid(logic [31:0] a, logic [31:0] b);
    logic [31:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Applies one request to the shadow FIFO and returns the report it causes.
  // Aggregates are folded oldest to newest; a zero entry forces LCM to zero,
  // otherwise saturation sticks once reached.
  function automatic fifo_report_t fifo_apply(fifo_req_t rq);
    fifo_report_t r;
    logic [31:0] mn, mx, orv, andv, g, l, v;
    logic [63:0] qt;
    logic        sat, zero;
    r = '0;
    r.status = agf_pkg::STS_DONE;
    if (rq.action == agf_pkg::ACT_PUSH) begin
      if (shadow_q.size() >= DEPTH_MAX) r.status = agf_pkg::STS_PUSH_FULL;
      else shadow_q.insert(shadow_q.size(), rq.value);
    end else begin
      if (shadow_q.size() == 0) r.status = agf_pkg::STS_POP_EMPTY;
      else void'(shadow_q.pop_front());
    end
    r.entry_count = 11'(shadow_q.size());
    r.is_empty    = (shadow_q.size() == 0);
    if (shadow_q.size() > 0) begin
      mn = shadow_q[0]; mx = mn; orv = mn; andv = mn; g = mn; l = mn;
      zero = (mn == 0);
      sat = 1'b0;
      for (int i = 1; i < shadow_q.size(); i++) begin
        v = shadow_q[i];
        if (v < mn) mn = v;
        if (v > mx) mx = v;
        orv  = orv | v;
        andv = andv & v;
        g    = euclid(g, v);
        if (zero || v == 0) begin
          zero = 1'b1; l = '0; sat = 1'b0;
        end else if (!sat) begin
          qt = 64'(l / euclid(l, v));
          if (qt > 64'hFFFF_FFFF / 64'(v)) begin
            sat = 1'b1; l = '1;
          end else begin
            l = 32'(qt * 64'(v));
          end
        end
      end
      r.min_value = mn;
      r.max_value = mx;
      r.or_value  = orv;
      r.and_value = andv;
      r.gcd_value = shadow_gcd_en ? g : '0;
      r.lcm_value = shadow_lcm_en ? l : '0;
      r.lcm_saturated = shadow_lcm_en && sat;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- driver
  int drv_idle;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      in_ch.action <= agf_pkg::ACT_PUSH;
      in_ch.value  <= '0;
      drv_idle = 0;
    end else begin
      // request accepted at this edge: predict its report
      if (in_ch.valid && in_ch.ready) begin
        fifo_req_t acc;
        acc.action = in_ch.action;
        acc.value  = in_ch.value;
        report_q.insert(report_q.size(), fifo_apply(acc));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (drv_idle == 0 && !calm && $urandom_range(0, 7) == 0)
          drv_idle = $urandom_range(1, 6);
        if (drv_idle > 0) begin
          drv_idle--;
          in_ch.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          fifo_req_t nx;
          nx = pending_q.pop_front();
          in_ch.valid  <= 1'b1;
          in_ch.action <= nx.action;
          in_ch.value  <= nx.value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------- hold counter
  int hold_cnt;
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
    end else if (hold_req > 0) begin
      hold_cnt <= hold_req;
      hold_req = 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // --------------------------------------------------------------- monitor
  int mon_idle;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      mon_idle = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        fifo_report_t got, want;
        got = '{out_ch.min_value, out_ch.max_value, out_ch.or_value, out_ch.and_value,
                out_ch.gcd_value, out_ch.lcm_value, out_ch.lcm_saturated,
                out_ch.entry_count, out_ch.is_empty, out_ch.status};
        n_reports++;
        if (report_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none actual %h", $time, got);
        end else begin
          want = report_q.pop_front();
          if (want.status != agf_pkg::STS_DONE) n_refused++;
          if (want.lcm_saturated) n_saturated++;
          if (got.min_value != want.min_value)
            $display("%0t: min_value expected %h actual %h", $time,
                     want.min_value, got.min_value);
          if (got.max_value != want.max_value)
            $display("%0t: max_value expected %h actual %h", $time,
                     want.max_value, got.max_value);
          if (got.or_value != want.or_value)
            $display("%0t: or_value expected %h actual %h", $time,
                     want.or_value, got.or_value);
          if (got.and_value != want.and_value)
            $display("%0t: and_value expected %h actual %h", $time,
                     want.and_value, got.and_value);
          if (got.gcd_value != want.gcd_value)
            $display("%0t: gcd_value expected %h actual %h", $time,
                     want.gcd_value, got.gcd_value);
          if (got.lcm_value != want.lcm_value)
            $display("%0t: lcm_value expected %h actual %h", $time,
                     want.lcm_value, got.lcm_value);
          if (got.lcm_saturated != want.lcm_saturated)
            $display("%0t: lcm_saturated expected %b actual %b", $time,
                     want.lcm_saturated, got.lcm_saturated);
          if (got.entry_count != want.entry_count)
            $display("%0t: entry_count expected %0d actual %0d", $time,
                     want.entry_count, got.entry_count);
          if (got.is_empty != want.is_empty)
            $display("%0t: is_empty expected %b actual %b", $time,
                     want.is_empty, got.is_empty);
          if (got.status != want.status)
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, got.status);
          if (got !== want) errors++;
        end
      end
      if (hold_cnt > 0) begin
        out_ch.ready <= 1'b0;
      end else begin
        if (mon_idle == 0 && !calm && $urandom_range(0, 6) == 0)
          mon_idle = $urandom_range(1, 6);
        if (mon_idle > 0) begin
          mon_idle--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // -------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               report_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ------------------------------------------------------------- stimulus
  int gen_depth;  // depth as the queued stimulus will leave it

  task automatic add_req(logic act, logic [31:0] val);
    fifo_req_t nr;
    nr.action = act;
    nr.value  = val;
    pending_q.insert(pending_q.size(), nr);
    if (act == agf_pkg::ACT_PUSH && gen_depth < DEPTH_MAX) gen_depth++;
    if (act == agf_pkg::ACT_POP && gen_depth > 0) gen_depth--;
  endtask

  // mostly small words so LCM stays in range, some zeros and full-range words
  function automatic logic [31:0] pick_word();
    int k;
    k = int'($urandom_range(0, 15));
    if (k < 2) return 32'd0;
    if (k < 6) return $urandom();
    if (k == 6) return 32'hFFFF_FFFF;
    return $urandom_range(1, 12);
  endfunction

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) begin
      if (gen_depth == 0 || (gen_depth < 24 && $urandom_range(0, 99) < 55))
        add_req(agf_pkg::ACT_PUSH, pick_word());
      else
        add_req(agf_pkg::ACT_POP, $urandom());
    end
  endtask

  // wait until every request went in and every report came back
  task automatic drain();
    do @(posedge clk);
    while (pending_q.size() != 0 || in_ch.valid || report_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == agf_pkg::CFG_GCD_EN) shadow_gcd_en = val;
    else shadow_lcm_en = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic directed();
    add_req(agf_pkg::ACT_POP, 32'hFFFF_FFFF);     // pop on empty
    add_req(agf_pkg::ACT_PUSH, 32'd0);
    add_req(agf_pkg::ACT_PUSH, 32'hFFFF_FFFF);
    add_req(agf_pkg::ACT_PUSH, 32'd12);
    add_req(agf_pkg::ACT_POP, 32'd0);             // moves the back stack over
    add_req(agf_pkg::ACT_PUSH, 32'd18);
    add_req(agf_pkg::ACT_POP, 32'd0);
    add_req(agf_pkg::ACT_PUSH, 32'hFFFF_FFFB);    // big primes-ish: LCM overflow
    add_req(agf_pkg::ACT_PUSH, 32'hFFFF_FFF1);
    add_req(agf_pkg::ACT_POP, 32'd0);
    add_req(agf_pkg::ACT_POP, 32'd0);
    add_req(agf_pkg::ACT_PUSH, 32'd0);            // zero entry clears saturation
    add_req(agf_pkg::ACT_POP, 32'd0);
    add_req(agf_pkg::ACT_POP, 32'd0);
    add_req(agf_pkg::ACT_POP, 32'd0);
    add_req(agf_pkg::ACT_POP, 32'd0);             // empty again
    add_req(agf_pkg::ACT_PUSH, 32'h8000_0000);
    add_req(agf_pkg::ACT_PUSH, 32'h0000_0001);
    add_req(agf_pkg::ACT_POP, 32'd0);
    add_req(agf_pkg::ACT_POP, 32'd0);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = agf_pkg::CFG_GCD_EN;
    cfg_data = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = agf_pkg::ACT_PUSH;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    shadow_gcd_en = 1'b0;
    shadow_lcm_en = 1'b0;
    errors = 0; cycles = 0; n_reports = 0; n_refused = 0; n_saturated = 0;
    calm = 1'b0; hold_req = 0; gen_depth = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: both disabled
    directed();
    drain();

    write_reg(agf_pkg::CFG_GCD_EN, 1'b1);
    write_reg(agf_pkg::CFG_LCM_EN, 1'b1);
    directed();
    add_random(150);
    drain();

    // deep fill with the receiver held off, then empty it
    write_reg(agf_pkg::CFG_LCM_EN, 1'b0);
    hold_req = 600;
    while (gen_depth < FILL_DEPTH) add_req(agf_pkg::ACT_PUSH, $urandom_range(1, 6));
    add_req(agf_pkg::ACT_POP, 32'd0);
    add_req(agf_pkg::ACT_PUSH, 32'd3);
    add_req(agf_pkg::ACT_PUSH, 32'd4);
    while (gen_depth > 0) add_req(agf_pkg::ACT_POP, $urandom());
    add_req(agf_pkg::ACT_POP, 32'd0);
    drain();

    write_reg(agf_pkg::CFG_GCD_EN, 1'b0);
    write_reg(agf_pkg::CFG_LCM_EN, 1'b1);
    add_random(180);
    drain();

    // last part without idling
    write_reg(agf_pkg::CFG_GCD_EN, 1'b1);
    calm = 1'b1;
    add_random(180);
    drain();
    repeat (50) @(posedge clk);

    $display("%0d results checked, %0d refused requests, %0d saturated LCMs,",
             n_reports, n_refused, n_saturated);
    $display("every enable setting, a deep fill under a held-off receiver, %0d cycles",
             cycles);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
src/agf_pkg.sv
src/agf_if.sv
src/agf_divider.sv
src/agf_combine.sv
src/aggregate_fifo_min_max_gcd.sv
src/agf_checker.sv
bench/tb_aggregate_fifo_min_max_gcd.sv
